FILE: src/htbd_pkg.sv
// htbd_pkg: shared widths, mode and status codes, and controller/datapath bundles
// for the huffman tree build and decode block; no dependencies
`timescale 1ns / 1ps

package htbd_pkg;

  // default sizing
  localparam int MAX_SYMBOLS_DEF     = 288;
  localparam int MAX_CODE_LENGTH_DEF = 15;

  // item field widths
  localparam int MODE_W   = 2;
  localparam int SYM_W    = 9;
  localparam int CODE_W   = 15;
  localparam int LEN_W    = 4;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 9;

  // register port
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;
  localparam int REG_IDX_W     = APB_ADDR_W - 2;
  localparam int NUM_CODES_RST = 288;

  localparam logic [REG_IDX_W-1:0] REG_NUM_CODES = '0;

  // item modes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DECODE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic latch;     // take the input item
    logic clr_step;  // write one cleared entry
    logic rd_first;  // checks and first tree read
    logic walk;      // evaluate one tree entry
    logic load_out;  // move the result into the output register
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;   // sweep at its last entry
    logic early;      // item finished without a tree walk
    logic walk_done;  // walk finished this cycle
    logic out_free;   // output register can take a result
  } dp_sts_t;

endpackage

FILE: src/htbd_cfg.sv
// htbd_cfg: apb-style register port holding num_codes and its clamped alphabet size
// depends on htbd_pkg
`timescale 1ns / 1ps

module htbd_cfg #(
  parameter int MAX_SYMBOLS = htbd_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [htbd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [htbd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [htbd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output logic [$clog2(MAX_SYMBOLS+1)-1:0] n_codes
);
  import htbd_pkg::*;

  localparam int CW    = $clog2(MAX_SYMBOLS + 1);
  localparam int XW    = ((CW > CFG_W) ? CW : CFG_W) + 1;
  localparam int N_RST = (NUM_CODES_RST > MAX_SYMBOLS) ? MAX_SYMBOLS : NUM_CODES_RST;

  logic [CFG_W-1:0] num_codes_r, num_codes_nxt;
  logic [CW-1:0]    n_codes_r, n_codes_nxt;
  logic             reg_sel;
  logic             wr_en;
  logic [XW-1:0]    wval_x;
  logic [XW-1:0]    eff_x;

  // address decode and write strobe
  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_NUM_CODES);
  assign wr_en   = psel & penable & pwrite & reg_sel;

  // clamp the alphabet size to [2, MAX_SYMBOLS]
  always_comb begin
    wval_x = XW'(pwdata[CFG_W-1:0]);
    if (wval_x < XW'(2)) begin
      eff_x = XW'(2);
    end else if (wval_x > XW'(MAX_SYMBOLS)) begin
      eff_x = XW'(MAX_SYMBOLS);
    end else begin
      eff_x = wval_x;
    end
  end

  always_comb begin
    num_codes_nxt = num_codes_r;
    n_codes_nxt   = n_codes_r;
    if (wr_en) begin
      num_codes_nxt = pwdata[CFG_W-1:0];
      n_codes_nxt   = eff_x[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_codes_r <= CFG_W'(NUM_CODES_RST);
      n_codes_r   <= CW'(N_RST);
    end else begin
      num_codes_r <= num_codes_nxt;
      n_codes_r   <= n_codes_nxt;
    end
  end

  // read back
  assign prdata  = reg_sel ? APB_DATA_W'(num_codes_r) : '0;
  assign pready  = 1'b1;
  assign n_codes = n_codes_r;

endmodule

FILE: src/htbd_ctrl.sv
// htbd_ctrl: sequencer for clear sweeps, insert walks, decode steps and result hand-off
// depends on htbd_pkg
`timescale 1ns / 1ps

module htbd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [htbd_pkg::MODE_W-1:0] in_mode,
  output logic                        in_ready,
  output htbd_pkg::ctl_cmd_t          cmd,
  input  htbd_pkg::dp_sts_t           sts
);
  import htbd_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       clr_item_r, clr_item_nxt;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    clr_item_nxt = clr_item_r;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = clr_item_r ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (in_mode)
            MODE_CLEAR: begin
              state_nxt    = S_CLEAR;
              clr_item_nxt = 1'b1;
            end
            MODE_INSERT, MODE_DECODE: begin
              state_nxt = S_READ;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.rd_first = 1'b1;
        state_nxt    = sts.early ? S_FINISH : S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.load_out = 1'b1;
        if (sts.out_free) begin
          state_nxt    = S_IDLE;
          clr_item_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // reset starts with a full clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_item_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_item_r <= clr_item_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_walk_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_INSERT || in_mode == MODE_DECODE)
    |=> state_r == S_READ)
    else $error("insert or decode item did not start with a tree read");

  a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> $past(state_r) == S_READ || $past(state_r) == S_WALK)
    else $error("walk entered without a first read");

  a_clear_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    clr_item_r && state_r == S_CLEAR && sts.clr_last |=> state_r == S_FINISH)
    else $error("clear item finished its sweep without a result");
`endif

endmodule

FILE: src/htbd_dp.sv
// htbd_dp: tree memory, item registers, walk evaluation and output register
// depends on htbd_pkg
`timescale 1ns / 1ps

module htbd_dp #(
  parameter int MAX_SYMBOLS     = htbd_pkg::MAX_SYMBOLS_DEF,
  parameter int MAX_CODE_LENGTH = htbd_pkg::MAX_CODE_LENGTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  htbd_pkg::ctl_cmd_t               cmd,
  output htbd_pkg::dp_sts_t                sts,
  input  logic [htbd_pkg::MODE_W-1:0]      in_mode,
  input  logic [htbd_pkg::SYM_W-1:0]       in_symbol,
  input  logic [htbd_pkg::CODE_W-1:0]      in_code_bits,
  input  logic [htbd_pkg::LEN_W-1:0]       in_code_length,
  input  logic                             in_next_bit,
  input  logic [$clog2(MAX_SYMBOLS+1)-1:0] n_codes,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [htbd_pkg::SYM_W-1:0]       out_decoded_symbol,
  output logic                             out_symbol_valid,
  output logic [htbd_pkg::STATUS_W-1:0]    out_status
);
  import htbd_pkg::*;

  localparam int DEPTH = 2 * MAX_SYMBOLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW - 1;
  localparam int XW    = ((AW > SYM_W) ? AW : SYM_W) + 1;
  localparam int LW    = LEN_W + 1;

  // tree memory: used flag over the child word
  logic [AW:0] mem [DEPTH];
  logic [AW:0] rdata_r;
  logic [AW-1:0] raddr, waddr;
  logic [AW:0]   wdata;
  logic          mem_we;

  // item and walk registers
  logic [MODE_W-1:0]   mode_r;
  logic [SYM_W-1:0]    sym_r;
  logic [CODE_W-1:0]   code_r;
  logic [LEN_W-1:0]    len_r;
  logic                bit_r;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]       addr_r;
  logic [PW-1:0]       nodes_r, nodes_nxt;
  logic [PW-1:0]       dpos_r, dpos_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [SYM_W-1:0]    res_sym_r, res_sym_nxt;
  logic                res_valid_r, res_valid_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_vld_r;
  logic [SYM_W-1:0]    out_sym_r;
  logic                out_sv_r;
  logic [STATUS_W-1:0] out_st_r;

  // walk arithmetic
  logic [XW-1:0] n_x, n_m2, w_x, w_m_n, nn_x, link_x, dpos_x, sym_x;
  logic          used, last, nb, first_bit;
  logic          len_zero, len_bad, sym_bad, clr_last;

  assign n_x       = XW'(n_codes);
  assign n_m2      = n_x - XW'(2);
  assign used      = rdata_r[AW];
  assign w_x       = XW'(rdata_r[AW-1:0]);
  assign w_m_n     = w_x - n_x;
  assign nn_x      = XW'(nodes_r) + XW'(1);
  assign link_x    = nn_x + n_x;
  assign dpos_x    = XW'(dpos_r);
  assign sym_x     = XW'(sym_r);
  assign last      = (cnt_r == '0);
  assign nb        = code_r[cnt_r - LEN_W'(1)];
  assign first_bit = code_r[len_r - LEN_W'(1)];
  assign len_zero  = (len_r == '0);
  assign len_bad   = LW'(len_r) > LW'(MAX_CODE_LENGTH);
  assign sym_bad   = (sym_x >= n_x);
  assign clr_last  = (clr_r == AW'(DEPTH - 1));

  // walk decisions, memory port selection and result capture
  always_comb begin
    raddr          = addr_r;
    mem_we         = 1'b0;
    waddr          = addr_r;
    wdata          = '0;
    cnt_nxt        = cnt_r;
    nodes_nxt      = nodes_r;
    dpos_nxt       = dpos_r;
    clr_nxt        = clr_r;
    res_sym_nxt    = res_sym_r;
    res_valid_nxt  = res_valid_r;
    res_status_nxt = res_status_r;
    sts            = '0;
    sts.clr_last   = clr_last;
    sts.out_free   = !out_vld_r || out_ready;

    if (cmd.latch) begin
      cnt_nxt        = in_code_length - LEN_W'(1);
      res_sym_nxt    = '0;
      res_valid_nxt  = 1'b0;
      res_status_nxt = ST_OK;
      if (in_mode == MODE_CLEAR) begin
        nodes_nxt = '0;
        dpos_nxt  = '0;
      end
    end

    // clearing sweep, one entry a cycle
    if (cmd.clr_step) begin
      mem_we  = 1'b1;
      waddr   = clr_r;
      clr_nxt = clr_last ? '0 : clr_r + AW'(1);
    end

    // item checks and first read
    if (cmd.rd_first) begin
      if (mode_r == MODE_INSERT) begin
        if (len_zero) begin
          sts.early = 1'b1;
        end else if (len_bad || sym_bad) begin
          sts.early      = 1'b1;
          res_status_nxt = ST_OVERFLOW;
        end else begin
          raddr = {PW'(0), first_bit};
        end
      end else begin
        raddr = {dpos_r, bit_r};
      end
    end

    // one tree entry per cycle
    if (cmd.walk) begin
      if (mode_r == MODE_INSERT) begin
        if (!used) begin
          if (last) begin
            mem_we        = 1'b1;
            wdata         = {1'b1, sym_x[AW-1:0]};
            sts.walk_done = 1'b1;
          end else if (nn_x > n_m2) begin
            sts.walk_done  = 1'b1;
            res_status_nxt = ST_OVERFLOW;
          end else begin
            mem_we    = 1'b1;
            wdata     = {1'b1, link_x[AW-1:0]};
            nodes_nxt = nn_x[PW-1:0];
            cnt_nxt   = cnt_r - LEN_W'(1);
            raddr     = {nn_x[PW-1:0], nb};
          end
        end else if (last || w_x < n_x || w_m_n > n_m2) begin
          sts.walk_done  = 1'b1;
          res_status_nxt = ST_OVERFLOW;
        end else begin
          cnt_nxt = cnt_r - LEN_W'(1);
          raddr   = {w_m_n[PW-1:0], nb};
        end
      end else begin
        sts.walk_done = 1'b1;
        dpos_nxt      = '0;
        if (dpos_x >= n_x || !used) begin
          res_status_nxt = ST_INVALID;
        end else if (w_x < n_x) begin
          res_sym_nxt   = w_x[SYM_W-1:0];
          res_valid_nxt = 1'b1;
        end else if (w_m_n >= n_x) begin
          res_status_nxt = ST_INVALID;
        end else begin
          dpos_nxt = w_m_n[PW-1:0];
        end
      end
    end
  end

  // tree memory, write-first on a same-address read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_we && waddr == raddr) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  // item payload and walk payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      sym_r  <= in_symbol;
      code_r <= in_code_bits;
      len_r  <= in_code_length;
      bit_r  <= in_next_bit;
    end
    addr_r       <= raddr;
    cnt_r        <= cnt_nxt;
    res_sym_r    <= res_sym_nxt;
    res_valid_r  <= res_valid_nxt;
    res_status_r <= res_status_nxt;
  end

  // tree bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r <= '0;
      dpos_r  <= '0;
      clr_r   <= '0;
    end else begin
      nodes_r <= nodes_nxt;
      dpos_r  <= dpos_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load_out && sts.out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out && sts.out_free) begin
      out_sym_r <= res_sym_r;
      out_sv_r  <= res_valid_r;
      out_st_r  <= res_status_r;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_decoded_symbol = out_sym_r;
  assign out_symbol_valid   = out_sv_r;
  assign out_status         = out_st_r;

`ifndef ASSERT_OFF
  a_symbol_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_sv_r |-> out_st_r == ST_OK)
    else $error("decoded symbol reported with an error status");

  a_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_sv_r |-> out_sym_r == '0)
    else $error("symbol field set without a completed symbol");

  a_sweep_rest: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.clr_step |-> clr_r == '0)
    else $error("clear counter left mid-sweep");
`endif

endmodule

FILE: src/huffman_tree_build_decode_top.sv
// huffman_tree_build_decode_top: huffman tree builder and bit-serial decoder
// depends on htbd_pkg, htbd_cfg, htbd_ctrl, htbd_dp
`timescale 1ns / 1ps

// Items arrive on the in_ valid/ready channel: mode clear, insert one code, decode
// one bit, or no operation. Every item gives exactly one result on the out_ channel:
// decoded symbol, symbol-valid flag and status (ok, build overflow, invalid node).
// The user must write num_codes through the apb-style port while no item is in
// flight; the block does not enforce this. One item is worked at a time by a
// sequencer around a two-port tree memory (one read and one write per cycle,
// registered read). Steps from accept to the result in the output register:
//   decode             check and read, evaluate entry, hand off
//   insert, length L   check and read, one memory entry per code bit, hand off
//   no operation       hand off; an insert rejected at the check skips the walk
//   clear              sweep of 2*MAX_SYMBOLS entries, one a cycle, hand off
// The next item is taken in the cycle after the hand-off.
// After reset the same sweep of 2*MAX_SYMBOLS entries runs with in_ready low.
// The output register holds its result while out_ready is low; a new item is taken
// meanwhile, and the sequencer waits at hand-off only if that result is still held.

module huffman_tree_build_decode_top #(
  parameter int MAX_SYMBOLS     = htbd_pkg::MAX_SYMBOLS_DEF,
  parameter int MAX_CODE_LENGTH = htbd_pkg::MAX_CODE_LENGTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [htbd_pkg::MODE_W-1:0]     in_mode,
  input  logic [htbd_pkg::SYM_W-1:0]      in_symbol,
  input  logic [htbd_pkg::CODE_W-1:0]     in_code_bits,
  input  logic [htbd_pkg::LEN_W-1:0]      in_code_length,
  input  logic                            in_next_bit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [htbd_pkg::SYM_W-1:0]      out_decoded_symbol,
  output logic                            out_symbol_valid,
  output logic [htbd_pkg::STATUS_W-1:0]   out_status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [htbd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [htbd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [htbd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import htbd_pkg::*;

  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  ctl_cmd_t      cmd;
  dp_sts_t       sts;
  logic [CW-1:0] n_codes;

  // register port
  htbd_cfg #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .n_codes (n_codes)
  );

  // sequencer
  htbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // tree memory and walk datapath
  htbd_dp #(
    .MAX_SYMBOLS     (MAX_SYMBOLS),
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_mode),
    .in_symbol          (in_symbol),
    .in_code_bits       (in_code_bits),
    .in_code_length     (in_code_length),
    .in_next_bit        (in_next_bit),
    .n_codes            (n_codes),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_decoded_symbol (out_decoded_symbol),
    .out_symbol_valid   (out_symbol_valid),
    .out_status         (out_status)
  );

endmodule

FILE: tb/sv/tb_huffman_tree_build_decode_top.sv
// tb_huffman_tree_build_decode_top: self-checking bench for the huffman tree block
// drives random prefix-code builds, bit-serial decodes and noise; depends on htbd_pkg
`timescale 1ns / 1ps

module tb_huffman_tree_build_decode_top;
  import htbd_pkg::*;

  localparam int STORE_DEPTH    = 2 * MAX_SYMBOLS_DEF;
  localparam int TARGET_ITEMS   = 1100;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              next_bit;
  } tree_op_t;

  typedef struct packed {
    logic [SYM_W-1:0]    symbol;
    logic                valid;
    logic [STATUS_W-1:0] status;
  } tree_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic [MODE_W-1:0] in_mode;
  logic [SYM_W-1:0] in_symbol;
  logic [CODE_W-1:0] in_code_bits;
  logic [LEN_W-1:0] in_code_length;
  logic in_next_bit;
  logic out_valid, out_ready;
  logic [SYM_W-1:0] out_decoded_symbol;
  logic out_symbol_valid;
  logic [STATUS_W-1:0] out_status;
  logic psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;
  logic pready;

  // predictor copy of the block state
  logic [9:0] tree_word [STORE_DEPTH];
  logic node_used [STORE_DEPTH];
  int unsigned inner_count;
  int unsigned walk_pos;
  logic [CFG_W-1:0] alphabet_size;

  tree_op_t queued_ops[$];
  tree_result_t predicted_results[$];
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  logic in_taken;

  huffman_tree_build_decode_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_symbol(in_symbol), .in_code_bits(in_code_bits),
    .in_code_length(in_code_length), .in_next_bit(in_next_bit),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_decoded_symbol(out_decoded_symbol), .out_symbol_valid(out_symbol_valid),
    .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // alphabet size as the block uses it
  function automatic int unsigned active_codes();
    if (alphabet_size < 2) return 2;
    if (alphabet_size > MAX_SYMBOLS_DEF) return MAX_SYMBOLS_DEF;
    return alphabet_size;
  endfunction

  // one item through the tree model, returns its result
  function automatic tree_result_t tree_step(input tree_op_t op);
    tree_result_t r;
    int unsigned n, pos, idx, w, i;
    logic b, last, done;
    r = '0;
    n = active_codes();
    case (op.mode)
      MODE_CLEAR: begin
        for (i = 0; i < STORE_DEPTH; i++) node_used[i] = 1'b0;
        inner_count = 0;
        walk_pos = 0;
      end
      MODE_INSERT: begin
        if (op.code_length != 0) begin
          if (op.code_length > MAX_CODE_LENGTH_DEF || op.symbol >= n) begin
            r.status = ST_OVERFLOW;
          end else begin
            pos = 0;
            done = 1'b0;
            for (i = 0; i < op.code_length && !done; i++) begin
              b = op.code_bits[op.code_length - i - 1];
              last = (i + 1 == op.code_length);
              if (pos > n - 2) begin
                r.status = ST_OVERFLOW;
                done = 1'b1;
              end else begin
                idx = 2 * pos + b;
                if (!node_used[idx]) begin
                  if (last) begin
                    tree_word[idx] = op.symbol;
                    node_used[idx] = 1'b1;
                  end else if (inner_count + 1 > n - 2) begin
                    // node pool exhausted
                    r.status = ST_OVERFLOW;
                    done = 1'b1;
                  end else begin
                    inner_count++;
                    tree_word[idx] = inner_count + n;
                    node_used[idx] = 1'b1;
                    pos = inner_count;
                  end
                end else begin
                  w = tree_word[idx];
                  // collision at the last bit or a leaf on the path
                  if (last || w < n) begin
                    r.status = ST_OVERFLOW;
                    done = 1'b1;
                  end else begin
                    pos = w - n;
                  end
                end
              end
            end
          end
        end
      end
      MODE_DECODE: begin
        if (walk_pos >= n) begin
          r.status = ST_INVALID;
          walk_pos = 0;
        end else begin
          idx = 2 * walk_pos + op.next_bit;
          if (!node_used[idx]) begin
            r.status = ST_INVALID;
            walk_pos = 0;
          end else begin
            w = tree_word[idx];
            if (w < n) begin
              r.symbol = w;
              r.valid = 1'b1;
              walk_pos = 0;
            end else if (w - n >= n) begin
              r.status = ST_INVALID;
              walk_pos = 0;
            end else begin
              walk_pos = w - n;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_item(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] symbol,
                            input logic [CODE_W-1:0] code_bits,
                            input logic [LEN_W-1:0] code_length, input logic next_bit);
    queued_ops.push_back('{mode, symbol, code_bits, code_length, next_bit});
    items_queued++;
  endtask

  // decode items that walk one code, msb first, other fields random
  task automatic queue_code(input logic [CODE_W-1:0] code, input int unsigned len);
    int unsigned i;
    for (i = len; i > 0; i--)
      queue_item(MODE_DECODE, $urandom_range(0, 511), $urandom_range(0, 32767),
                 $urandom_range(0, 15), code[i-1]);
  endtask

  // random item of any mode, mostly stray decode bits and bad inserts
  task automatic queue_noise();
    int unsigned r;
    logic [SYM_W-1:0] sym;
    r = $urandom_range(0, 99);
    sym = $urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(0, active_codes() - 1);
    if (r < 55)
      queue_item(MODE_DECODE, sym, $urandom_range(0, 32767), $urandom_range(0, 15),
                 $urandom_range(0, 1));
    else if (r < 80)
      queue_item(MODE_INSERT, sym, $urandom_range(0, 32767), $urandom_range(0, 15),
                 $urandom_range(0, 1));
    else if (r < 93)
      queue_item(MODE_NOP, sym, $urandom_range(0, 32767), $urandom_range(0, 15),
                 $urandom_range(0, 1));
    else
      queue_item(MODE_CLEAR, sym, $urandom_range(0, 32767), $urandom_range(0, 15),
                 $urandom_range(0, 1));
  endtask

  // hold the sender off until every item has its result
  task automatic wait_drained();
    while (items_accepted != items_queued || predicted_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write with random upper data bits, then read back
  task automatic set_num_codes(input logic [CFG_W-1:0] value);
    alphabet_size = value;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_NUM_CODES, 2'b00};
    pwdata <= {23'($urandom_range(0, 8388607)), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(APB_DATA_W - CFG_W){1'b0}}, value}) begin
      $display("%0t: num_codes read expected %0d got %0d", $time, value, prdata);
      mismatch_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // item driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin : driver
    tree_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (queued_ops.size() > 0) begin
        op = queued_ops.pop_front();
        in_valid <= 1'b1;
        in_mode <= op.mode;
        in_symbol <= op.symbol;
        in_code_bits <= op.code_bits;
        in_code_length <= op.code_length;
        in_next_bit <= op.next_bit;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: switches at random among four out_ready stall patterns
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;
  logic [31:0] rx_tick = '0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(32, 256);
      end else begin
        rx_left--;
      end
      rx_tick++;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) < 7);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_tick[2:0] < 3'd5);
      endcase
    end
  end

  // monitor: check results, predict accepted items, watchdog
  always @(posedge clk) begin : monitor
    tree_result_t want;
    tree_op_t op;
    if (!rst_n) begin
      in_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result with none expected: symbol %0d valid %0d status %0d",
                   $time, out_decoded_symbol, out_symbol_valid, out_status);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_decoded_symbol !== want.symbol) begin
            $display("%0t: decoded_symbol expected %0d got %0d", $time, want.symbol,
                     out_decoded_symbol);
            mismatch_count++;
          end
          if (out_symbol_valid !== want.valid) begin
            $display("%0t: symbol_valid expected %0d got %0d", $time, want.valid,
                     out_symbol_valid);
            mismatch_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        op = '{in_mode, in_symbol, in_code_bits, in_code_length, in_next_bit};
        predicted_results.push_back(tree_step(op));
        items_accepted++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[huffman_tree_build_decode_top] ERROR");
        $finish;
      end
    end
  end

  // stimulus: directed corner cases, then random build and decode phases
  initial begin : stimulus
    int unsigned n_eff, k, kmax, j, d, phase, i;
    int unsigned leaf_code[$], leaf_len[$], leaf_sym[$], pool[$], order[$];
    int unsigned c, l;
    logic [CODE_W-1:0] cb;
    logic [CFG_W-1:0] ncfg;
    logic partial_tree;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_NOP;
    in_symbol = '0;
    in_code_bits = '0;
    in_code_length = '0;
    in_next_bit = 1'b0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (i = 0; i < STORE_DEPTH; i++) node_used[i] = 1'b0;
    inner_count = 0;
    walk_pos = 0;
    alphabet_size = NUM_CODES_RST;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // clearing sweep after reset
    @(negedge clk);
    while (!in_ready) @(negedge clk);

    // default alphabet: empty tree, nop, zero length, longest code, bad inserts
    queue_item(MODE_DECODE, 0, 0, 0, 0);
    queue_item(MODE_NOP, 511, 15'h7FFF, 15, 1);
    queue_item(MODE_INSERT, 9, 15'h7FFF, 0, 1);
    queue_item(MODE_INSERT, 287, 15'h7FFF, 15, 0);
    queue_item(MODE_INSERT, 288, 0, 1, 0);
    queue_item(MODE_INSERT, 0, 0, 1, 0);
    queue_item(MODE_INSERT, 5, 0, 1, 0);
    queue_item(MODE_INSERT, 6, 0, 2, 0);
    queue_code(15'h7FFF, 15);
    // leave the decode walk two nodes deep
    queue_code(15'h0003, 2);
    wait_drained();

    // smallest alphabet: walk past the alphabet, pointer too far, leaf, empty pool
    set_num_codes(2);
    queue_item(MODE_DECODE, 0, 0, 0, 0);
    queue_item(MODE_DECODE, 0, 0, 0, 1);
    queue_item(MODE_DECODE, 0, 0, 0, 0);
    queue_item(MODE_CLEAR, 0, 0, 0, 0);
    queue_item(MODE_INSERT, 1, 0, 2, 0);
    wait_drained();
    set_num_codes(3);
    queue_item(MODE_INSERT, 2, 0, 3, 0);
    wait_drained();
    // shrunk alphabet turns a node pointer into a walk position too high
    set_num_codes(2);
    queue_item(MODE_INSERT, 1, 0, 2, 0);
    wait_drained();

    phase = 0;
    while (items_queued < TARGET_ITEMS) begin
      case ($urandom_range(0, 9))
        0: ncfg = 2;
        1: ncfg = 288;
        2: ncfg = $urandom_range(0, 511);
        3: ncfg = $urandom_range(3, 8);
        default: ncfg = $urandom_range(2, 288);
      endcase
      if (phase == 0) ncfg = 288;
      set_num_codes(ncfg);
      n_eff = active_codes();

      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        // random prefix code: split leaves until k symbols
        kmax = (n_eff < 12) ? n_eff : 12;
        if ($urandom_range(0, 4) == 0) kmax = (n_eff < 48) ? n_eff : 48;
        k = $urandom_range(2, kmax);
        leaf_code = '{0, 1};
        leaf_len = '{1, 1};
        while (leaf_code.size() < k) begin
          j = $urandom_range(0, 1) ? leaf_code.size() - 1
                                   : $urandom_range(0, leaf_code.size() - 1);
          if (leaf_len[j] < MAX_CODE_LENGTH_DEF) begin
            c = leaf_code[j];
            l = leaf_len[j];
            leaf_code.delete(j);
            leaf_len.delete(j);
            leaf_code.push_back(c << 1);
            leaf_len.push_back(l + 1);
            leaf_code.push_back((c << 1) | 1);
            leaf_len.push_back(l + 1);
          end
        end
        // distinct symbols for the leaves
        pool.delete();
        leaf_sym.delete();
        for (i = 0; i < n_eff; i++) pool.push_back(i);
        for (i = 0; i < k; i++) begin
          j = $urandom_range(0, pool.size() - 1);
          leaf_sym.push_back(pool[j]);
          pool.delete(j);
        end
        // build in random order, sometimes leaving codes out
        queue_item(MODE_CLEAR, $urandom_range(0, 511), $urandom_range(0, 32767),
                   $urandom_range(0, 15), $urandom_range(0, 1));
        order.delete();
        for (i = 0; i < k; i++) order.push_back(i);
        partial_tree = ($urandom_range(0, 7) == 0);
        while (order.size() > 0) begin
          j = $urandom_range(0, order.size() - 1);
          i = order[j];
          order.delete(j);
          if ($urandom_range(0, 19) == 0) queue_noise();
          if (!(partial_tree && $urandom_range(0, 4) == 0)) begin
            // bits above the code length are don't-care
            cb = $urandom_range(0, 32767);
            cb = (cb << leaf_len[i]) | leaf_code[i];
            queue_item(MODE_INSERT, leaf_sym[i], cb, leaf_len[i], $urandom_range(0, 1));
          end
        end
        // decode a stream of random symbols
        d = $urandom_range(6, 24);
        for (i = 0; i < d; i++) begin
          if ($urandom_range(0, 9) == 0) queue_noise();
          j = $urandom_range(0, k - 1);
          queue_code(leaf_code[j], leaf_len[j]);
        end
        if ($urandom_range(0, 1) == 0) queue_code($urandom_range(0, 15), $urandom_range(1, 4));
      end else begin
        // keep the old tree under the new alphabet size
        d = $urandom_range(10, 40);
        for (i = 0; i < d; i++) queue_noise();
      end
      wait_drained();
      phase++;
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0)
      $display("[huffman_tree_build_decode_top] OK");
    else
      $display("[huffman_tree_build_decode_top] ERROR");
    $finish;
  end

endmodule
